>>> rtl/bbr_pkg.sv
// shared types and constants of the 5x5 box blur
`default_nettype none
package bbr_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WID_W       = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = 16;
    localparam int CFG_WID_W   = 12;
    localparam int CFG_HGT_W   = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int RADIUS      = 2;
    localparam int WIN         = 2 * RADIUS + 1;
    localparam int LINES       = 4;
    localparam int SLOT_W      = 2;
    localparam int NUM_CH      = 3;
    localparam int CH_W        = 8;
    localparam int CSUM_W      = 11;
    localparam int TSUM_W      = 13;
    localparam int DIV_SHIFT   = 17;
    localparam int DIV_MUL     = (2 ** DIV_SHIFT + WIN * WIN - 1) / (WIN * WIN);
    localparam int DIV_MUL_W   = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [CFG_WID_W-1:0] RESET_WIDTH  = CFG_WID_W'(640);
    localparam logic [CFG_HGT_W-1:0] RESET_HEIGHT = CFG_HGT_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pixel;

    typedef struct packed {
        logic            operation;
        logic [CH_W-1:0] chan_blue;
        logic [CH_W-1:0] chan_green;
        logic [CH_W-1:0] chan_red;
    } t_in_beat;

    typedef struct packed {
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_red;
        logic            frame_end;
    } t_out_beat;

    typedef struct packed {
        logic              pixel;
        t_pixel            px;
        logic [COL_W-1:0]  x;
        logic [SLOT_W-1:0] wslot;
        logic              emit;
        logic              inner;
        logic [SLOT_W-1:0] pslot;
        logic [COL_W-1:0]  pcol;
        logic              fend;
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/bbr_front.sv
// front end: configuration, position tracking and item classification
`default_nettype none
module bbr_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    input  wire  [bbr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [bbr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                               i_accept,
    input  bbr_pkg::t_in_beat                 i_beat,
    output logic                              o_push,
    output bbr_pkg::t_cmd                     o_cmd
);

    logic [bbr_pkg::CFG_WID_W-1:0] r_cfg_w;
    logic [bbr_pkg::CFG_HGT_W-1:0] r_cfg_h;
    logic [bbr_pkg::COL_W-1:0]     r_in_col, n_in_col, r_out_col, n_out_col;
    logic [bbr_pkg::ROW_W-1:0]     r_in_row, n_in_row, r_out_row, n_out_row;

    logic [bbr_pkg::WID_W-1:0]     w;
    logic [bbr_pkg::ROW_W-1:0]     h;
    logic [bbr_pkg::COL_W-1:0]     x, oc;
    logic [bbr_pkg::ROW_W-1:0]     rr, orow;
    logic [bbr_pkg::WID_W-1:0]     col_inc, ocol_inc;
    logic [bbr_pkg::ROW_W:0]       orow_p2;
    logic [bbr_pkg::WID_W:0]       ocol_p2;
    logic                          emit;

    always_comb begin
        if (r_cfg_w == '0) begin
            w = bbr_pkg::WID_W'(1);
        end else if (32'(r_cfg_w) > bbr_pkg::MAX_WIDTH) begin
            w = bbr_pkg::WID_W'(bbr_pkg::MAX_WIDTH);
        end else begin
            w = bbr_pkg::WID_W'(r_cfg_w);
        end
        h = (r_cfg_h == '0) ? bbr_pkg::ROW_W'(1) : r_cfg_h;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        x         = r_in_col;
        rr        = r_in_row;
        emit      = 1'b0;
        if (i_beat.operation == bbr_pkg::OP_DRAIN) begin
            emit = (r_in_row >= h);
        end else begin
            if (r_in_row >= h || bbr_pkg::WID_W'(r_in_col) >= w) begin
                x         = '0;
                rr        = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
            emit = (rr >= bbr_pkg::ROW_W'(4))
                || (rr == bbr_pkg::ROW_W'(3) && w >= bbr_pkg::WID_W'(2))
                || (rr == bbr_pkg::ROW_W'(2) && x >= bbr_pkg::COL_W'(2));
            col_inc = bbr_pkg::WID_W'(x) + bbr_pkg::WID_W'(1);
            if (col_inc >= w) begin
                n_in_col = '0;
                n_in_row = rr + bbr_pkg::ROW_W'(1);
            end else begin
                n_in_col = col_inc[bbr_pkg::COL_W-1:0];
                n_in_row = rr;
            end
        end
        oc       = n_out_col;
        orow     = n_out_row;
        col_inc  = bbr_pkg::WID_W'(x) + bbr_pkg::WID_W'(1);
        ocol_inc = bbr_pkg::WID_W'(oc) + bbr_pkg::WID_W'(1);
        orow_p2  = {1'b0, orow} + (bbr_pkg::ROW_W + 1)'(bbr_pkg::RADIUS);
        ocol_p2  = {1'b0, bbr_pkg::WID_W'(oc)} + (bbr_pkg::WID_W + 1)'(bbr_pkg::RADIUS);
        if (emit) begin
            if (ocol_inc >= w) begin
                n_out_col = '0;
                n_out_row = orow + bbr_pkg::ROW_W'(1);
            end else begin
                n_out_col = ocol_inc[bbr_pkg::COL_W-1:0];
            end
            if (n_out_row >= h) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end
    end

    always_comb begin
        o_push         = i_accept && (i_beat.operation == bbr_pkg::OP_PIXEL || emit);
        o_cmd.pixel    = (i_beat.operation == bbr_pkg::OP_PIXEL);
        o_cmd.px       = {i_beat.chan_red, i_beat.chan_green, i_beat.chan_blue};
        o_cmd.x        = x;
        o_cmd.wslot    = rr[bbr_pkg::SLOT_W-1:0];
        o_cmd.emit     = emit;
        o_cmd.inner    = (w >= bbr_pkg::WID_W'(bbr_pkg::WIN))
                      && (h >= bbr_pkg::ROW_W'(bbr_pkg::WIN))
                      && (orow >= bbr_pkg::ROW_W'(bbr_pkg::RADIUS))
                      && (orow_p2 < {1'b0, h})
                      && (oc >= bbr_pkg::COL_W'(bbr_pkg::RADIUS))
                      && (ocol_p2 < {1'b0, w});
        o_cmd.pslot    = orow[bbr_pkg::SLOT_W-1:0];
        o_cmd.pcol     = oc;
        o_cmd.fend     = (orow == h - bbr_pkg::ROW_W'(1))
                      && (bbr_pkg::WID_W'(oc) == w - bbr_pkg::WID_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= bbr_pkg::RESET_WIDTH;
            r_cfg_h   <= bbr_pkg::RESET_HEIGHT;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bbr_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg_w   <= i_cfg_data[bbr_pkg::CFG_WID_W-1:0];
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
                bbr_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg_h   <= i_cfg_data[bbr_pkg::CFG_HGT_W-1:0];
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule
`default_nettype wire

>>> rtl/bbr_queue.sv
// command queue between front end and datapath
`default_nettype none
module bbr_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  bbr_pkg::t_cmd  i_cmd,
    input  wire            i_pop,
    output bbr_pkg::t_cmd  o_cmd,
    output logic           o_nonempty,
    output logic           o_full
);

    bbr_pkg::t_cmd                 r_slot [bbr_pkg::QUEUE_DEPTH];
    logic [bbr_pkg::QUEUE_AW-1:0]  r_wptr, r_rptr;
    logic [bbr_pkg::QUEUE_AW:0]    r_count;
    logic                          do_push, do_pop;

    assign o_full     = (r_count == (bbr_pkg::QUEUE_AW + 1)'(bbr_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_cmd      = r_slot[r_rptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + bbr_pkg::QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + bbr_pkg::QUEUE_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (bbr_pkg::QUEUE_AW + 1)'(1);
                2'b01:   r_count <= r_count - (bbr_pkg::QUEUE_AW + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/bbr_back.sv
// datapath: line store banks, column sums, window total, divide by area for inner pixels, border pixels passed through
`default_nettype none
module bbr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  bbr_pkg::t_cmd       i_cmd,
    input  wire                 i_cmd_valid,
    output logic                o_pop,
    input  wire                 i_ready,
    output logic                o_valid,
    output bbr_pkg::t_out_beat  o_data
);

    logic                        adv;
    bbr_pkg::t_pixel             r_col_rd [bbr_pkg::LINES];
    bbr_pkg::t_pixel             r_pt_rd  [bbr_pkg::LINES];
    logic                        r_s1_v, r_s1_byp;
    bbr_pkg::t_cmd               r_s1_cmd;
    logic [bbr_pkg::CSUM_W-1:0]  r_cs [bbr_pkg::WIN][bbr_pkg::NUM_CH];
    logic [bbr_pkg::CSUM_W-1:0]  newcol [bbr_pkg::NUM_CH];
    bbr_pkg::t_pixel             pt;
    logic                        r_s2_v, r_s2_inner, r_s2_fend;
    bbr_pkg::t_pixel             r_s2_pt;
    logic                        r_s3_v, r_s3_inner, r_s3_fend;
    bbr_pkg::t_pixel             r_s3_pt;
    logic [bbr_pkg::TSUM_W-1:0]  r_s3_sum [bbr_pkg::NUM_CH];
    logic                        r_out_valid;
    bbr_pkg::t_pixel             r_out_px;
    logic                        r_out_fend;
    bbr_pkg::t_pixel             quot;

    assign adv   = !r_out_valid || i_ready;
    assign o_pop = adv && i_cmd_valid;

    for (genvar b = 0; b < bbr_pkg::LINES; b++) begin : g_bank
        bbr_pkg::t_pixel r_mem [bbr_pkg::MAX_WIDTH];
        always_ff @(posedge i_clk) begin
            if (o_pop) begin
                r_col_rd[b] <= r_mem[i_cmd.x];
                r_pt_rd[b]  <= r_mem[i_cmd.pcol];
                if (i_cmd.pixel && i_cmd.wslot == bbr_pkg::SLOT_W'(b)) begin
                    r_mem[i_cmd.x] <= i_cmd.px;
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < bbr_pkg::NUM_CH; c++) begin
            newcol[c] = bbr_pkg::CSUM_W'(r_s1_cmd.px[c]);
            for (int b = 0; b < bbr_pkg::LINES; b++) begin
                newcol[c] = newcol[c] + bbr_pkg::CSUM_W'(r_col_rd[b][c]);
            end
        end
        pt = r_s1_byp ? r_s1_cmd.px : r_pt_rd[r_s1_cmd.pslot];
    end

    always_comb begin
        for (int c = 0; c < bbr_pkg::NUM_CH; c++) begin
            logic [bbr_pkg::TSUM_W+bbr_pkg::DIV_MUL_W-1:0] prod;
            prod = (bbr_pkg::TSUM_W + bbr_pkg::DIV_MUL_W)'(r_s3_sum[c])
                 * (bbr_pkg::TSUM_W + bbr_pkg::DIV_MUL_W)'(bbr_pkg::DIV_MUL);
            quot[c] = prod[bbr_pkg::DIV_SHIFT +: bbr_pkg::CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < bbr_pkg::WIN; j++) begin
                for (int c = 0; c < bbr_pkg::NUM_CH; c++) begin
                    r_cs[j][c] <= '0;
                end
            end
        end else if (adv) begin
            r_s1_v      <= o_pop;
            r_s2_v      <= r_s1_v && r_s1_cmd.emit;
            r_s3_v      <= r_s2_v;
            r_out_valid <= r_s3_v;
            if (r_s1_v && r_s1_cmd.pixel) begin
                for (int j = 0; j < bbr_pkg::WIN - 1; j++) begin
                    r_cs[j] <= r_cs[j + 1];
                end
                r_cs[bbr_pkg::WIN-1] <= newcol;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_cmd   <= i_cmd;
            r_s1_byp   <= i_cmd.pixel && (i_cmd.wslot == i_cmd.pslot) && (i_cmd.x == i_cmd.pcol);
            r_s2_inner <= r_s1_cmd.inner;
            r_s2_fend  <= r_s1_cmd.fend;
            r_s2_pt    <= pt;
            r_s3_inner <= r_s2_inner;
            r_s3_fend  <= r_s2_fend;
            r_s3_pt    <= r_s2_pt;
            for (int c = 0; c < bbr_pkg::NUM_CH; c++) begin
                r_s3_sum[c] <= bbr_pkg::TSUM_W'(r_cs[0][c]) + bbr_pkg::TSUM_W'(r_cs[1][c])
                             + bbr_pkg::TSUM_W'(r_cs[2][c]) + bbr_pkg::TSUM_W'(r_cs[3][c])
                             + bbr_pkg::TSUM_W'(r_cs[4][c]);
            end
            r_out_px   <= r_s3_inner ? quot : r_s3_pt;
            r_out_fend <= r_s3_fend;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_data.out_blue  = r_out_px[0];
    assign o_data.out_green = r_out_px[1];
    assign o_data.out_red   = r_out_px[2];
    assign o_data.frame_end = r_out_fend;

endmodule
`default_nettype wire

>>> rtl/box_blur_5x5_rgb.sv
// top level of the streaming 5x5 rgb box blur
// path: input beat, command queue, back end stages s1 to s3, then the output register
// throughput: one beat per cycle while o_ready; back end advances whenever output register frees
// four line store banks: one write and two reads per cycle, one pixel a cycle unless stalled
// reset: synchronous active low, clears positions, queue, pipeline valids and window sums
// reset: line store is not cleared, width 640 and height 480 after reset
`default_nettype none
module box_blur_5x5_rgb (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  bbr_pkg::t_in_beat                i_data,
    output logic                             o_valid,
    input  wire                              i_ready,
    output bbr_pkg::t_out_beat               o_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [bbr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [bbr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic          push, pop, q_nonempty, q_full, accept;
    bbr_pkg::t_cmd f_cmd, q_cmd;

    assign o_ready     = !q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    bbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_beat      (i_data),
        .o_push      (push),
        .o_cmd       (f_cmd)
    );

    bbr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (f_cmd),
        .i_pop      (pop),
        .o_cmd      (q_cmd),
        .o_nonempty (q_nonempty),
        .o_full     (q_full)
    );

    bbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_nonempty),
        .o_pop       (pop),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire

>>> rtl/bbr_checker.sv
// port level checks of the box blur and their bind
`default_nettype none
module bbr_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_ready,
    input wire                 o_valid,
    input wire                 i_ready,
    input bbr_pkg::t_out_beat  o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");

    a_reset_no_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

endmodule

bind box_blur_5x5_rgb bbr_checker u_bbr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench of the streaming 5x5 rgb box blur
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_GAP   = 10;

    class blur_scoreboard;
        bit [23:0]           lines [bbr_pkg::LINES*bbr_pkg::MAX_WIDTH];
        bit [23:0]           win [bbr_pkg::WIN][bbr_pkg::WIN];
        int unsigned         icol, irow, ocol, orow;
        bit [11:0]           wreg;
        bit [15:0]           hreg;
        bbr_pkg::t_out_beat  blurred_q [$];
        int                  errors;

        function new();
            wreg = bbr_pkg::RESET_WIDTH;
            hreg = bbr_pkg::RESET_HEIGHT;
            errors = 0;
            clear_pos();
        endfunction

        function int unsigned eff_w();
            if (wreg == 0) return 1;
            if (wreg > bbr_pkg::MAX_WIDTH) return bbr_pkg::MAX_WIDTH;
            return wreg;
        endfunction

        function int unsigned eff_h();
            return (hreg == 0) ? 1 : hreg;
        endfunction

        function void clear_pos();
            icol = 0; irow = 0; ocol = 0; orow = 0;
        endfunction

        function void set_reg(logic [bbr_pkg::CFG_IDX_W-1:0] idx,
                              logic [bbr_pkg::CFG_DATA_W-1:0] d);
            if (idx == bbr_pkg::CFG_IMAGE_WIDTH) wreg = d[11:0];
            else if (idx == bbr_pkg::CFG_IMAGE_HEIGHT) hreg = d;
            else return;
            clear_pos();
        endfunction

        function void produce(int unsigned w, int unsigned h);
            int unsigned        r, c, sb, sg, sr;
            bit                 inner;
            bit [23:0]          p;
            bbr_pkg::t_out_beat o;
            r = orow; c = ocol;
            inner = w >= bbr_pkg::WIN && h >= bbr_pkg::WIN &&
                    r >= bbr_pkg::RADIUS && r + bbr_pkg::RADIUS < h &&
                    c >= bbr_pkg::RADIUS && c + bbr_pkg::RADIUS < w;
            sb = 0; sg = 0; sr = 0;
            if (inner) begin
                for (int i = 0; i < bbr_pkg::WIN; i++)
                    for (int j = 0; j < bbr_pkg::WIN; j++) begin
                        p = win[i][j];
                        sb += p[7:0]; sg += p[15:8]; sr += p[23:16];
                    end
                sb /= bbr_pkg::WIN * bbr_pkg::WIN;
                sg /= bbr_pkg::WIN * bbr_pkg::WIN;
                sr /= bbr_pkg::WIN * bbr_pkg::WIN;
            end else begin
                p = lines[(r % bbr_pkg::LINES) * bbr_pkg::MAX_WIDTH
                          + (c % bbr_pkg::MAX_WIDTH)];
                sb = p[7:0]; sg = p[15:8]; sr = p[23:16];
            end
            o.out_blue  = sb[7:0];
            o.out_green = sg[7:0];
            o.out_red   = sr[7:0];
            o.frame_end = (r == h - 1 && c == w - 1);
            blurred_q = {blurred_q, o};
            ocol++;
            if (ocol >= w) begin
                ocol = 0; orow++;
            end
            if (orow >= h) clear_pos();
        endfunction

        function void note_input(bbr_pkg::t_in_beat b);
            int unsigned w, h, x, rr, idx;
            bit [23:0]   px;
            w = eff_w(); h = eff_h();
            if (b.operation == bbr_pkg::OP_DRAIN) begin
                if (irow < h) return;
                produce(w, h);
                return;
            end
            if (irow >= h || icol >= w) clear_pos();
            px = {b.chan_red, b.chan_green, b.chan_blue};
            x = icol; rr = irow;
            for (int i = 0; i < bbr_pkg::WIN; i++)
                for (int j = 0; j < bbr_pkg::WIN - 1; j++)
                    win[i][j] = win[i][j + 1];
            for (int i = 0; i < bbr_pkg::WIN - 1; i++)
                win[i][bbr_pkg::WIN-1] =
                    lines[((rr + i) % bbr_pkg::LINES) * bbr_pkg::MAX_WIDTH + x];
            win[bbr_pkg::WIN-1][bbr_pkg::WIN-1] = px;
            lines[(rr % bbr_pkg::LINES) * bbr_pkg::MAX_WIDTH + x] = px;
            idx = rr * w + x;
            icol++;
            if (icol >= w) begin
                icol = 0; irow++;
            end
            if (idx >= bbr_pkg::RADIUS * w + bbr_pkg::RADIUS) produce(w, h);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(bbr_pkg::t_out_beat o);
            bbr_pkg::t_out_beat e;
            if (blurred_q.size() == 0) begin
                report($sformatf("unexpected beat %h", o));
                return;
            end
            e = blurred_q.pop_front();
            if (o.out_blue !== e.out_blue)
                report($sformatf("blue got %h want %h", o.out_blue, e.out_blue));
            if (o.out_green !== e.out_green)
                report($sformatf("green got %h want %h", o.out_green, e.out_green));
            if (o.out_red !== e.out_red)
                report($sformatf("red got %h want %h", o.out_red, e.out_red));
            if (o.frame_end !== e.frame_end)
                report($sformatf("frame_end got %b want %b", o.frame_end, e.frame_end));
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    bbr_pkg::t_in_beat              i_data;
    logic                           o_valid;
    logic                           i_ready;
    bbr_pkg::t_out_beat             o_data;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [bbr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bbr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    blur_scoreboard sb;
    int  cyc;
    int  beats_sent;
    bit  burst;
    bit  stall_req;
    bit  stall_done;
    int  stall_left;

    box_blur_5x5_rgb u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side: random back pressure plus one long hold-off
    always @(posedge i_clk) begin
        if (stall_req && !stall_done) begin
            stall_done = 1'b1;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= burst ? 1'b1 : ($urandom_range(99) >= 32);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check(o_data);
    end

    task send_beat(input bbr_pkg::t_in_beat b);
        int gap;
        gap = (!burst && $urandom_range(99) < 32) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(b);
        beats_sent++;
    endtask

    task send_pixel(input logic [7:0] bl, input logic [7:0] gr, input logic [7:0] rd);
        bbr_pkg::t_in_beat b;
        b.operation = bbr_pkg::OP_PIXEL;
        b.chan_blue = bl; b.chan_green = gr; b.chan_red = rd;
        send_beat(b);
    endtask

    task send_drain();
        bbr_pkg::t_in_beat b;
        b.operation = bbr_pkg::OP_DRAIN;
        b.chan_blue = 8'($urandom); b.chan_green = 8'($urandom); b.chan_red = 8'($urandom);
        send_beat(b);
    endtask

    task send_rand_pixel();
        int k;
        k = $urandom_range(9);
        if (k == 0) send_pixel(8'hff, 8'hff, 8'hff);
        else if (k == 1) send_pixel(8'h00, 8'h00, 8'h00);
        else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task write_reg(input logic [bbr_pkg::CFG_IDX_W-1:0] idx,
                   input logic [bbr_pkg::CFG_DATA_W-1:0] d);
        i_valid <= 1'b0;
        while (sb.blurred_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
    endtask

    task blur_frame(input int npix, input int ndrain);
        for (int i = 0; i < npix; i++) send_rand_pixel();
        for (int i = 0; i < ndrain; i++) send_drain();
    endtask

    initial begin
        int w, h, kind, phase;
        sb = new();
        cyc = 0; beats_sent = 0;
        burst = 1'b0; stall_req = 1'b0; stall_done = 1'b0; stall_left = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_data = '0; i_ready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset size, early drain, extremes of channels, zero sizes
        send_drain();
        send_pixel(8'h12, 8'h34, 8'h56);
        send_pixel(8'hff, 8'h00, 8'haa);
        write_reg(bbr_pkg::CFG_IMAGE_WIDTH, 16'd5);
        write_reg(bbr_pkg::CFG_IMAGE_HEIGHT, 16'd5);
        for (int i = 0; i < 25; i++) begin
            if (i == 12) send_drain();
            if (i % 2 == 0) send_pixel(8'hff, 8'hff, 8'hff);
            else send_pixel(8'h00, 8'h80, 8'hff);
        end
        for (int i = 0; i < 13; i++) send_drain();
        write_reg(bbr_pkg::CFG_IMAGE_WIDTH, 16'd0);
        write_reg(bbr_pkg::CFG_IMAGE_HEIGHT, 16'd0);
        send_pixel(8'h01, 8'h02, 8'h03);
        send_pixel(8'hfe, 8'hfd, 8'hfc);
        send_drain();
        send_drain();

        // clamped width with a partial frame, then a partial frame of the tallest height
        write_reg(bbr_pkg::CFG_IMAGE_WIDTH, 16'hffff);
        write_reg(bbr_pkg::CFG_IMAGE_HEIGHT, 16'd5);
        blur_frame(40, 2);
        write_reg(bbr_pkg::CFG_IMAGE_WIDTH, 16'd1);
        write_reg(bbr_pkg::CFG_IMAGE_HEIGHT, 16'hffff);
        blur_frame(20, 3);

        phase = 0;
        while (beats_sent < 600) begin
            burst = (phase >= 4 && phase < 8);
            w = ($urandom_range(9) == 0) ? $urandom_range(20, 13) : $urandom_range(12, 1);
            h = $urandom_range(9, 1);
            if (phase == 2) begin
                w = 12; h = 9;
            end
            if (phase == 0 || phase == 2 || $urandom_range(3) != 0) begin
                write_reg(bbr_pkg::CFG_IMAGE_WIDTH, 16'(w));
                write_reg(bbr_pkg::CFG_IMAGE_HEIGHT, 16'(h));
            end else begin
                w = sb.eff_w(); h = sb.eff_h();
            end
            stall_req = (phase == 2);
            kind = $urandom_range(9);
            if (kind < 7) begin
                blur_frame(w * h, 2 * w + 2 + $urandom_range(2));
            end else if (kind == 7) begin
                blur_frame($urandom_range(w * h), $urandom_range(3));
            end else if (kind == 8) begin
                blur_frame(w * h, $urandom_range(w + 1));
                blur_frame(w * h, 2 * w + 2);
            end else begin
                for (int i = 0; i < w * h; i++) begin
                    if ($urandom_range(3) == 0) send_drain();
                    else send_rand_pixel();
                end
                blur_frame(0, 2 * w + 3);
            end
            phase++;
        end
        burst = 1'b0;
        i_valid <= 1'b0;

        while (sb.blurred_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.blurred_q.size() != 0)
            sb.report($sformatf("%0d beats never came", sb.blurred_q.size()));
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/bbr_pkg.sv
rtl/bbr_front.sv
rtl/bbr_queue.sv
rtl/bbr_back.sv
rtl/box_blur_5x5_rgb.sv
rtl/bbr_checker.sv
tb/sv/tb.sv
